// ===== hw/rtl/lsmb_pkg.sv =====
// Package for the logistic soft-mix blender: formats, pipeline depth,
// configuration types and the elaboration-time logistic sample table.
// No dependencies.
`default_nettype none

package lsmb_pkg;

  // Channel format: unsigned fixed point, CHAN_FRAC_BITS fraction bits.
  localparam int CHAN_FRAC_BITS = 15;
  localparam int CHAN_W         = 16;
  localparam int CH_ONE         = 1 << CHAN_FRAC_BITS;
  localparam int OUT_MAX        = (CH_ONE > 65535) ? 65535 : CH_ONE;

  // Logistic table: SIG_ENTRIES intervals over t in [-8, 8).
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
  localparam int TAB_IDX_W   = $clog2(SIG_ENTRIES + 1);
  localparam int SAMPLE_W    = 16;

  // Steepness product t is held in units of 2^-(CHAN_FRAC_BITS+8).
  localparam int T_SHIFT = CHAN_FRAC_BITS + 8;
  localparam int OFF_W   = T_SHIFT + 4;
  localparam int FR_W    = OFF_W - SIG_BITS;

  // Datapath widths.
  localparam int D_W    = CHAN_W + 2;
  localparam int K_W    = 14;
  localparam int T_W    = K_W + 1 + D_W;
  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int PROD_W = DIFF_W + FR_W + 1;
  localparam int PD_W   = CHAN_W + 2;
  localparam int NUM_W  = 28;

  // Register stages from an accepted item to its result strobe.
  localparam int LAT = 8;

  // Configuration register map (word index on the APB port).
  typedef enum logic [0:0] {
    REG_INTENSITY = 1'b0,
    REG_OPACITY   = 1'b1
  } reg_idx_e;

  // Configuration seen by each channel datapath.
  typedef struct packed {
    logic [K_W-1:0] k;        // 10 * intensity
    logic [8:0]     opacity;  // Q.8
  } cfg_t;

  typedef logic [SIG_ENTRIES:0][SAMPLE_W-1:0] sig_tab_t;

  // Unsigned long division by shift and subtract. It only runs while the
  // sample table is built at elaboration.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One logistic sample at t = -8 + 16k/SIG_ENTRIES. e^-|t| comes from a
  // fourth-order series at |t|/256, squared eight times, all in Q30.
  function automatic logic [SAMPLE_W-1:0] sig_sample(int unsigned k);
    logic signed [63:0] sd;
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x4;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] q30;
    logic [63:0] one64;
    int i;
    q30   = 64'd1 << 30;
    one64 = 64'(CH_ONE);
    sd  = 64'(16 * k) - 64'(8 * SIG_ENTRIES);
    mag = (sd < 0) ? 64'(-sd) : 64'(sd);
    x   = udiv64((mag << 30) + 64'(128 * SIG_ENTRIES), 64'(256 * SIG_ENTRIES));
    x2  = (x * x + (q30 >> 1)) >> 30;
    x3  = (x2 * x + (q30 >> 1)) >> 30;
    x4  = (x3 * x + (q30 >> 1)) >> 30;
    e   = q30 - x + (x2 >> 1) - udiv64(x3, 64'd6) + udiv64(x4, 64'd24);
    for (i = 0; i < 8; i++) begin
      e = (e * e + (q30 >> 1)) >> 30;
    end
    s = udiv64((one64 << 30) + ((q30 + e) >> 1), q30 + e);
    return SAMPLE_W'((sd < 0) ? (one64 - s) : s);
  endfunction

  // Whole table, evaluated at elaboration.
  function automatic sig_tab_t sig_table();
    sig_tab_t tab;
    int k;
    for (k = 0; k <= SIG_ENTRIES; k++) begin
      tab[k] = sig_sample(k);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsmb_chan.sv =====
// One color channel of the blender: eight register stages from the channel
// pair to the saturated result. Depends on lsmb_pkg for formats and table.
`default_nettype none

module lsmb_chan
  import lsmb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cfg_t              cfg_i,
  input  wire logic [CHAN_W-1:0] src_i,
  input  wire logic [CHAN_W-1:0] dst_i,
  output logic      [CHAN_W-1:0] out_o
);

  localparam sig_tab_t SIG_TAB = sig_table();
  localparam logic signed [T_W-1:0] T_LO = -(T_W'(1) <<< (T_SHIFT + 3));
  localparam logic signed [T_W-1:0] T_HI = (T_W'(1) <<< (T_SHIFT + 3)) - T_W'(1);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FR_W - 1);

  // Stage 1: centered sum d = src + dst - 1.0.
  logic signed [D_W-1:0]    d_d, d_q;
  logic        [CHAN_W-1:0] dst1_q;

  assign d_d = $signed({2'b00, src_i}) + $signed({2'b00, dst_i}) - D_W'(CH_ONE);

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    dst1_q <= dst_i;
  end

  // Stage 2: steepness product t = 10 * intensity * d.
  logic signed [T_W-1:0]    t_d, t_q;
  logic signed [K_W:0]      k_s;
  logic        [CHAN_W-1:0] dst2_q;

  assign k_s = $signed({1'b0, cfg_i.k});
  assign t_d = T_W'(k_s) * T_W'(d_q);

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    dst2_q <= dst1_q;
  end

  // Stage 3: clamp t to the table span and split it into index and fraction.
  logic [OFF_W-1:0]    off;
  logic [SIG_BITS-1:0] idx_q;
  logic [FR_W-1:0]     fr3_q;
  logic [CHAN_W-1:0]   dst3_q;

  always_comb begin
    if (t_q < T_LO) begin
      off = '0;
    end else if (t_q > T_HI) begin
      off = '1;
    end else begin
      off = OFF_W'(t_q - T_LO);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= off[OFF_W-1 -: SIG_BITS];
    fr3_q  <= off[FR_W-1:0];
    dst3_q <= dst2_q;
  end

  // Stage 4: fetch the two neighboring samples and their difference.
  logic [TAB_IDX_W-1:0]     ia, ib;
  logic [SAMPLE_W-1:0]      a_d, a4_q;
  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic [FR_W-1:0]          fr4_q;
  logic [CHAN_W-1:0]        dst4_q;

  assign ia     = TAB_IDX_W'(idx_q);
  assign ib     = ia + TAB_IDX_W'(1);
  assign a_d    = SIG_TAB[ia];
  assign diff_d = $signed({2'b00, SIG_TAB[ib]}) - $signed({2'b00, a_d});

  always_ff @(posedge clk_i) begin
    a4_q   <= a_d;
    diff_q <= diff_d;
    fr4_q  <= fr3_q;
    dst4_q <= dst3_q;
  end

  // Stage 5: interpolation product.
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [SAMPLE_W-1:0]      a5_q;
  logic [CHAN_W-1:0]        dst5_q;

  assign prod_d = PROD_W'(diff_q) * PROD_W'($signed({1'b0, fr4_q}));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a5_q   <= a4_q;
    dst5_q <= dst4_q;
  end

  // Stage 6: round the step half away from zero, add it to the lower
  // sample, and form p - dst.
  logic                   neg;
  logic [PROD_W-1:0]      mag;
  logic [PD_W-1:0]        r;
  logic signed [PD_W-1:0] p;
  logic signed [PD_W-1:0] pd_d, pd_q;
  logic [CHAN_W-1:0]      dst6_q;

  always_comb begin
    neg  = prod_q[PROD_W-1];
    mag  = neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    r    = PD_W'((mag + HALF) >> FR_W);
    p    = $signed({2'b00, a5_q}) + (neg ? -$signed(r) : $signed(r));
    pd_d = p - $signed({2'b00, dst5_q});
  end

  always_ff @(posedge clk_i) begin
    pd_q   <= pd_d;
    dst6_q <= dst5_q;
  end

  // Stage 7: opacity times (p - dst).
  logic signed [NUM_W-1:0] m_d, m_q;
  logic [CHAN_W-1:0]       dst7_q;

  assign m_d = NUM_W'($signed({1'b0, cfg_i.opacity})) * NUM_W'(pd_q);

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    dst7_q <= dst6_q;
  end

  // Stage 8: add the destination back, round to nearest, saturate.
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] o;
  logic [CHAN_W-1:0]       out_d, out_q;

  always_comb begin
    num = $signed({4'b0000, dst7_q, 8'h00}) + m_q + NUM_W'(128);
    o   = num >>> 8;
    if (o < 0) begin
      out_d = '0;
    end else if (o > NUM_W'(OUT_MAX)) begin
      out_d = CHAN_W'(OUT_MAX);
    end else begin
      out_d = o[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/logistic_soft_mix_blend.sv =====
// Logistic soft-mix blender on lsmb_pkg and lsmb_chan; busy is always low.
// The done strobe and result are registered; each pixel passes eight register stages per
// channel, set by the multiply and table steps.
// Throughput: one pixel per cycle; the receiver cannot stall the pipeline.
// Reset clears the valid chain; intensity and opacity reset to 256 (1.0).
`default_nettype none

module logistic_soft_mix_blend
  import lsmb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // Pixel command interface
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CHAN_W-1:0] src_red_i,
  input  wire logic [CHAN_W-1:0] src_green_i,
  input  wire logic [CHAN_W-1:0] src_blue_i,
  input  wire logic [CHAN_W-1:0] dst_red_i,
  input  wire logic [CHAN_W-1:0] dst_green_i,
  input  wire logic [CHAN_W-1:0] dst_blue_i,
  input  wire logic [CHAN_W-1:0] dst_alpha_i,
  output logic                   done_o,
  output logic      [CHAN_W-1:0] out_red_o,
  output logic      [CHAN_W-1:0] out_green_o,
  output logic      [CHAN_W-1:0] out_blue_o,
  output logic      [CHAN_W-1:0] out_alpha_o
);

  // Configuration registers.
  logic [9:0] intensity_q;
  logic [8:0] opacity_q;
  logic       cfg_wr;
  reg_idx_e   reg_sel;
  cfg_t       cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= 10'd256;
      opacity_q   <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_INTENSITY: intensity_q <= pwdata[9:0];
        REG_OPACITY:   opacity_q   <= pwdata[8:0];
        default:       ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_sel)
      REG_INTENSITY: prdata = 32'(intensity_q);
      REG_OPACITY:   prdata = 32'(opacity_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg.k       = K_W'(intensity_q) * K_W'(10);
  assign cfg.opacity = opacity_q;

  // The pipeline never stalls, so a command transfer happens whenever
  // start is high.
  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Valid bits travel alongside the channel stages.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign done_o = vld_q[LAT-1];

  // Alpha is delayed to line up with the color channels.
  logic [CHAN_W-1:0] alpha_q [LAT];

  always_ff @(posedge clk_i) begin
    alpha_q[0] <= dst_alpha_i;
    for (int i = 1; i < LAT; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  assign out_alpha_o = alpha_q[LAT-1];

  // Color channel datapaths.
  lsmb_chan u_chan_red (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .src_i (src_red_i),
    .dst_i (dst_red_i),
    .out_o (out_red_o)
  );

  lsmb_chan u_chan_green (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .src_i (src_green_i),
    .dst_i (dst_green_i),
    .out_o (out_green_o)
  );

  lsmb_chan u_chan_blue (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .src_i (src_blue_i),
    .dst_i (dst_blue_i),
    .out_o (out_blue_o)
  );

`ifndef SYNTHESIS
  // Every result strobe comes from an earlier transfer carried down the valid chain.
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without a matching input transfer");

  // Alpha stays aligned with the strobe.
  a_alpha_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_alpha_o == $past(dst_alpha_i, LAT)))
    else $error("alpha out of step with the color pipeline");

  // Saturation bounds every color result.
  a_color_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_red_o <= CHAN_W'(OUT_MAX)) && (out_green_o <= CHAN_W'(OUT_MAX))
                && (out_blue_o <= CHAN_W'(OUT_MAX))))
    else $error("color result above full scale");
`endif

endmodule

`default_nettype wire
